@@ rtl/core/z80alu_pkg.sv @@
// z80alu_pkg: shared types, operation codes, flag positions and flag helpers
// for the z80 alu. No dependencies; the channel interfaces and the top level import it.
package z80alu_pkg;

	typedef logic [4:0]  action_t;
	typedef logic [15:0] word_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  bitnum_t;

	localparam action_t ACT_INC       = 5'd0;
	localparam action_t ACT_DEC       = 5'd1;
	localparam action_t ACT_ADD       = 5'd2;
	localparam action_t ACT_ADC       = 5'd3;
	localparam action_t ACT_SUB       = 5'd4;
	localparam action_t ACT_SBC       = 5'd5;
	localparam action_t ACT_AND       = 5'd6;
	localparam action_t ACT_OR        = 5'd7;
	localparam action_t ACT_XOR       = 5'd8;
	localparam action_t ACT_CP        = 5'd9;
	localparam action_t ACT_ADD16     = 5'd10;
	localparam action_t ACT_ADC16     = 5'd11;
	localparam action_t ACT_SBC16     = 5'd12;
	localparam action_t ACT_RLC       = 5'd13;
	localparam action_t ACT_RRC       = 5'd14;
	localparam action_t ACT_RL        = 5'd15;
	localparam action_t ACT_RR        = 5'd16;
	localparam action_t ACT_SLA       = 5'd17;
	localparam action_t ACT_SRA       = 5'd18;
	localparam action_t ACT_SRL       = 5'd19;
	localparam action_t ACT_SLL       = 5'd20;
	localparam action_t ACT_BIT       = 5'd21;
	localparam action_t ACT_BITMEMPTR = 5'd22;
	localparam action_t ACT_SET       = 5'd23;
	localparam action_t ACT_RES       = 5'd24;

	// flag byte bit positions
	localparam int unsigned FLAG_S  = 7;
	localparam int unsigned FLAG_Z  = 6;
	localparam int unsigned FLAG_5  = 5;
	localparam int unsigned FLAG_H  = 4;
	localparam int unsigned FLAG_3  = 3;
	localparam int unsigned FLAG_PV = 2;
	localparam int unsigned FLAG_N  = 1;
	localparam int unsigned FLAG_C  = 0;

	// sign, zero and the two undocumented bits of an 8-bit value
	function automatic byte_t sz35(input byte_t v);
		byte_t f;
		f = 8'h00;
		f[FLAG_S] = v[7];
		f[FLAG_Z] = (v == 8'h00);
		f[FLAG_5] = v[5];
		f[FLAG_3] = v[3];
		return f;
	endfunction

	// sz35 plus parity (pv set on even parity)
	function automatic byte_t szp35(input byte_t v);
		byte_t f;
		f = sz35(v);
		f[FLAG_PV] = ~^v;
		return f;
	endfunction

endpackage

@@ rtl/core/z80alu_req_if.sv @@
// z80alu_req_if: request channel of the z80 alu, valid/ready plus the operation fields.
// Depends on z80alu_pkg.
interface z80alu_req_if import z80alu_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	word_t   first_operand;
	word_t   second_operand;
	byte_t   flags_in;
	bitnum_t bit_number;
	word_t   memptr_in;

	modport source (
		output valid, action, first_operand, second_operand, flags_in, bit_number, memptr_in,
		input  ready
	);
	modport sink (
		input  valid, action, first_operand, second_operand, flags_in, bit_number, memptr_in,
		output ready
	);
endinterface

@@ rtl/core/z80alu_rsp_if.sv @@
// z80alu_rsp_if: result channel of the z80 alu, valid/ready plus result, flags and memptr.
// Depends on z80alu_pkg.
interface z80alu_rsp_if import z80alu_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t result_value;
	byte_t flags_out;
	word_t memptr_out;
	logic  memptr_written;

	modport source (
		output valid, result_value, flags_out, memptr_out, memptr_written,
		input  ready
	);
	modport sink (
		input  valid, result_value, flags_out, memptr_out, memptr_written,
		output ready
	);
endinterface

@@ rtl/core/z80_alu_with_flags.sv @@
// z80_alu_with_flags: z80 alu with full flag generation (undocumented bits 3/5 included).
// Structure: input register (stage 1), one pass of alu logic, result register (stage 2).
// Throughput: one beat per cycle while the result channel is not stalled.
// A held result stalls requests only once stage 1 is full as well; stage 1 drains into stage 2.
// Reset (arst_n low, asynchronous) clears the two stage valid bits only.
// Depends on z80alu_pkg, z80alu_req_if and z80alu_rsp_if.
module z80_alu_with_flags
	import z80alu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	z80alu_req_if.sink    req,
	z80alu_rsp_if.source  rsp
);

	// stage 1: registered request
	logic    valid_s1;
	action_t action_s1;
	word_t   op1_s1;
	word_t   op2_s1;
	byte_t   flags_s1;
	bitnum_t bitnum_s1;
	word_t   memptr_s1;

	// stage 2: registered result
	logic    valid_s2;
	word_t   result_s2;
	byte_t   flags_s2;
	word_t   memptr_s2;
	logic    mpw_s2;

	logic    adv_s2;
	logic    take_s1;

	assign adv_s2  = !valid_s2 || rsp.ready;
	assign take_s1 = !valid_s1 || adv_s2;
	assign req.ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && take_s1) begin
			action_s1 <= req.action;
			op1_s1    <= req.first_operand;
			op2_s1    <= req.second_operand;
			flags_s1  <= req.flags_in;
			bitnum_s1 <= req.bit_number;
			memptr_s1 <= req.memptr_in;
		end
	end

	// operand views
	byte_t a;
	byte_t r;
	logic  cin;
	byte_t mask;
	logic  cin8;
	logic  cin16;
	byte_t inc8;
	byte_t dec8;
	logic [8:0]  add9;
	logic [8:0]  sub9;
	logic [16:0] add17;
	logic [16:0] sub17;
	logic        is16;

	assign a     = op1_s1[7:0];
	assign r     = op2_s1[7:0];
	assign cin   = flags_s1[FLAG_C];
	assign mask  = 8'(8'h01 << bitnum_s1);
	assign cin8  = (action_s1 == ACT_ADC || action_s1 == ACT_SBC) ? cin : 1'b0;
	assign cin16 = (action_s1 == ACT_ADD16) ? 1'b0 : cin;
	assign inc8  = r + 8'h01;
	assign dec8  = r - 8'h01;
	assign add9  = {1'b0, a} + {1'b0, r} + {8'h00, cin8};
	assign sub9  = {1'b0, a} - {1'b0, r} - {8'h00, cin8};
	assign add17 = {1'b0, op1_s1} + {1'b0, op2_s1} + {16'h0000, cin16};
	assign sub17 = {1'b0, op1_s1} - {1'b0, op2_s1} - {16'h0000, cin16};
	assign is16  = (action_s1 == ACT_ADD16 || action_s1 == ACT_ADC16 ||
	                action_s1 == ACT_SBC16);

	// rotate and shift unit
	byte_t sh_res;
	logic  sh_cout;

	always_comb begin
		sh_res  = r;
		sh_cout = 1'b0;
		case (action_s1)
			ACT_RLC: begin sh_res = {r[6:0], r[7]};  sh_cout = r[7]; end
			ACT_RL:  begin sh_res = {r[6:0], cin};   sh_cout = r[7]; end
			ACT_SLA: begin sh_res = {r[6:0], 1'b0};  sh_cout = r[7]; end
			ACT_SLL: begin sh_res = {r[6:0], 1'b1};  sh_cout = r[7]; end
			ACT_RRC: begin sh_res = {r[0], r[7:1]};  sh_cout = r[0]; end
			ACT_RR:  begin sh_res = {cin, r[7:1]};   sh_cout = r[0]; end
			ACT_SRA: begin sh_res = {r[7], r[7:1]};  sh_cout = r[0]; end
			ACT_SRL: begin sh_res = {1'b0, r[7:1]};  sh_cout = r[0]; end
			default: begin sh_res = r;               sh_cout = 1'b0; end
		endcase
	end

	// main alu
	word_t res_c;
	byte_t flags_c;
	byte_t ar8;
	logic [16:0] ar16;

	always_comb begin
		res_c   = op1_s1;
		flags_c = flags_s1;
		ar8     = 8'h00;
		ar16    = 17'h00000;
		case (action_s1)
			ACT_INC: begin
				res_c = {8'h00, inc8};
				flags_c = sz35(inc8);
				flags_c[FLAG_H]  = (inc8[3:0] == 4'h0);
				flags_c[FLAG_PV] = (inc8 == 8'h80);
				flags_c[FLAG_C]  = cin;
			end
			ACT_DEC: begin
				res_c = {8'h00, dec8};
				flags_c = sz35(dec8);
				flags_c[FLAG_H]  = (r[3:0] == 4'h0);
				flags_c[FLAG_PV] = (dec8 == 8'h7f);
				flags_c[FLAG_N]  = 1'b1;
				flags_c[FLAG_C]  = cin;
			end
			ACT_ADD, ACT_ADC: begin
				ar8 = add9[7:0];
				res_c = {8'h00, ar8};
				flags_c = sz35(ar8);
				flags_c[FLAG_H]  = a[4] ^ r[4] ^ add9[4];
				flags_c[FLAG_PV] = (a[7] ^ add9[7]) & (r[7] ^ add9[7]);
				flags_c[FLAG_C]  = add9[8];
			end
			ACT_SUB, ACT_SBC, ACT_CP: begin
				ar8 = sub9[7:0];
				flags_c = sz35(ar8);
				flags_c[FLAG_H]  = a[4] ^ r[4] ^ sub9[4];
				flags_c[FLAG_PV] = (a[7] ^ r[7]) & (a[7] ^ sub9[7]);
				flags_c[FLAG_N]  = 1'b1;
				flags_c[FLAG_C]  = sub9[8];
				if (action_s1 == ACT_CP) begin
					// compare keeps a and takes bits 3 and 5 from the operand
					res_c = {8'h00, a};
					flags_c[FLAG_5] = r[5];
					flags_c[FLAG_3] = r[3];
				end else begin
					res_c = {8'h00, ar8};
				end
			end
			ACT_AND: begin
				ar8 = a & r;
				res_c = {8'h00, ar8};
				flags_c = szp35(ar8);
				flags_c[FLAG_H] = 1'b1;
			end
			ACT_OR: begin
				ar8 = a | r;
				res_c = {8'h00, ar8};
				flags_c = szp35(ar8);
			end
			ACT_XOR: begin
				ar8 = a ^ r;
				res_c = {8'h00, ar8};
				flags_c = szp35(ar8);
			end
			ACT_ADD16, ACT_ADC16, ACT_SBC16: begin
				flags_c = 8'h00;
				if (action_s1 == ACT_SBC16) begin
					ar16 = sub17;
					flags_c[FLAG_N]  = 1'b1;
					flags_c[FLAG_PV] = (op1_s1[15] ^ op2_s1[15]) & (op1_s1[15] ^ sub17[15]);
				end else begin
					ar16 = add17;
					flags_c[FLAG_PV] = (op1_s1[15] ^ add17[15]) & (op2_s1[15] ^ add17[15]);
				end
				res_c = ar16[15:0];
				flags_c[FLAG_S] = ar16[15];
				flags_c[FLAG_Z] = (ar16[15:0] == 16'h0000);
				flags_c[FLAG_5] = ar16[13];
				flags_c[FLAG_H] = op1_s1[12] ^ op2_s1[12] ^ ar16[12];
				flags_c[FLAG_3] = ar16[11];
				flags_c[FLAG_C] = ar16[16];
				if (action_s1 == ACT_ADD16) begin
					// 16-bit add leaves s, z and pv alone
					flags_c[FLAG_S]  = flags_s1[FLAG_S];
					flags_c[FLAG_Z]  = flags_s1[FLAG_Z];
					flags_c[FLAG_PV] = flags_s1[FLAG_PV];
				end
			end
			ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SRL, ACT_SLL: begin
				res_c = {8'h00, sh_res};
				flags_c = szp35(sh_res);
				flags_c[FLAG_C] = sh_cout;
			end
			ACT_BIT, ACT_BITMEMPTR: begin
				res_c = {8'h00, a};
				flags_c = 8'h00;
				flags_c[FLAG_C]  = cin;
				flags_c[FLAG_H]  = 1'b1;
				flags_c[FLAG_Z]  = ((r & mask) == 8'h00);
				flags_c[FLAG_PV] = ((r & mask) == 8'h00);
				flags_c[FLAG_S]  = (bitnum_s1 == 3'd7) && r[7];
				if (action_s1 == ACT_BIT) begin
					flags_c[FLAG_5] = r[5];
					flags_c[FLAG_3] = r[3];
				end else begin
					flags_c[FLAG_5] = memptr_s1[13];
					flags_c[FLAG_3] = memptr_s1[11];
				end
			end
			ACT_SET: begin
				res_c = {8'h00, r | mask};
			end
			ACT_RES: begin
				res_c = {8'h00, r & ~mask};
			end
			default: begin
				res_c   = op1_s1;
				flags_c = flags_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			result_s2 <= res_c;
			flags_s2  <= flags_c;
			memptr_s2 <= is16 ? (op1_s1 + 16'h0001) : memptr_s1;
			mpw_s2    <= is16;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.result_value   = result_s2;
	assign rsp.flags_out      = flags_s2;
	assign rsp.memptr_out     = memptr_s2;
	assign rsp.memptr_written = mpw_s2;

`ifndef SYNTHESIS
	// an accepted request beat always lands in stage 1
	a_req_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request beat missing from stage 1");

	// a stage-1 item blocked by a full output register stays put
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(action_s1) && $stable(op1_s1))
		else $error("stage 1 item lost while output stalled");

	// memptr write flag follows the operation that moved into stage 2
	a_mpw_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> rsp.valid && (rsp.memptr_written == $past(is16)))
		else $error("memptr write flag does not match the operation");
`endif

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for z80_alu_with_flags, random and directed operations
// with random stalls on both channels. Depends on z80alu_pkg, z80alu_req_if, z80alu_rsp_if.
module tb_top;
	import z80alu_pkg::*;

	localparam action_t ACT_SPARE_LAST = 5'd31;

	typedef struct packed {
		action_t action;
		word_t   first_operand;
		word_t   second_operand;
		byte_t   flags_in;
		bitnum_t bit_number;
		word_t   memptr_in;
	} alu_op_t;

	typedef struct packed {
		word_t result_value;
		byte_t flags_out;
		word_t memptr_out;
		logic  memptr_written;
	} alu_out_t;

	typedef struct packed {
		action_t  action;
		alu_out_t want;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	z80alu_req_if req_ch ();
	z80alu_rsp_if rsp_ch ();

	z80_alu_with_flags dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	alu_op_t     queued_ops[$];
	outcome_t    pending_outcomes[$];
	alu_op_t     next_op;
	outcome_t    head_outcome;
	int unsigned src_gap, src_calm, sink_gap, sink_calm;
	int unsigned error_count = 0;

	always #5 clk = ~clk;

	// sign, zero and the undocumented 5/3 copies of an 8-bit value
	function automatic byte_t szxy_flags(input byte_t v);
		byte_t f;
		f = 8'h00;
		f[FLAG_S] = v[7];
		f[FLAG_Z] = (v == 8'h00);
		f[FLAG_5] = v[5];
		f[FLAG_3] = v[3];
		return f;
	endfunction

	function automatic alu_out_t compute_alu_outcome(input alu_op_t op);
		alu_out_t    o;
		byte_t       a, r, v, f, mask, src;
		logic        cin, sub, cy, cout;
		logic [8:0]  s9;
		logic [16:0] s17;
		a = op.first_operand[7:0];
		r = op.second_operand[7:0];
		cin = op.flags_in[FLAG_C];
		mask = byte_t'(1) << op.bit_number;
		sub = (op.action == ACT_SUB) || (op.action == ACT_SBC) || (op.action == ACT_CP)
			|| (op.action == ACT_SBC16);
		cy = cin && ((op.action == ACT_ADC) || (op.action == ACT_SBC)
			|| (op.action == ACT_ADC16) || (op.action == ACT_SBC16));
		o.result_value = op.first_operand;
		o.memptr_out = op.memptr_in;
		o.memptr_written = 1'b0;
		f = op.flags_in;
		case (op.action)
			ACT_INC: begin
				v = r + 8'd1;
				f = szxy_flags(v);
				f[FLAG_H] = (v[3:0] == 4'h0);
				f[FLAG_PV] = (v == 8'h80);
				f[FLAG_C] = cin;
				o.result_value = {8'h00, v};
			end
			ACT_DEC: begin
				v = r - 8'd1;
				f = szxy_flags(v);
				f[FLAG_H] = (r[3:0] == 4'h0);
				f[FLAG_PV] = (v == 8'h7F);
				f[FLAG_N] = 1'b1;
				f[FLAG_C] = cin;
				o.result_value = {8'h00, v};
			end
			ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC, ACT_CP: begin
				s9 = sub ? ({1'b0, a} - {1'b0, r} - cy) : ({1'b0, a} + {1'b0, r} + cy);
				v = s9[7:0];
				f = szxy_flags(v);
				f[FLAG_H] = a[4] ^ r[4] ^ v[4];
				f[FLAG_PV] = sub ? ((a[7] ^ r[7]) & (a[7] ^ v[7]))
					: ((a[7] ^ v[7]) & (r[7] ^ v[7]));
				f[FLAG_N] = sub;
				f[FLAG_C] = s9[8];
				if (op.action == ACT_CP) begin
					// compare copies 5/3 from the operand, accumulator kept
					f[FLAG_5] = r[5];
					f[FLAG_3] = r[3];
					o.result_value = {8'h00, a};
				end else begin
					o.result_value = {8'h00, v};
				end
			end
			ACT_AND, ACT_OR, ACT_XOR: begin
				v = (op.action == ACT_AND) ? (a & r) : (op.action == ACT_OR) ? (a | r) : (a ^ r);
				f = szxy_flags(v);
				f[FLAG_PV] = ~^v;
				f[FLAG_H] = (op.action == ACT_AND);
				o.result_value = {8'h00, v};
			end
			ACT_ADD16, ACT_ADC16, ACT_SBC16: begin
				s17 = sub ? ({1'b0, op.first_operand} - {1'b0, op.second_operand} - cy)
					: ({1'b0, op.first_operand} + {1'b0, op.second_operand} + cy);
				f = 8'h00;
				f[FLAG_S] = s17[15];
				f[FLAG_Z] = (s17[15:0] == 16'h0000);
				f[FLAG_5] = s17[13];
				f[FLAG_H] = op.first_operand[12] ^ op.second_operand[12] ^ s17[12];
				f[FLAG_3] = s17[11];
				f[FLAG_PV] = sub
					? ((op.first_operand[15] ^ op.second_operand[15]) & (op.first_operand[15] ^ s17[15]))
					: ((op.first_operand[15] ^ s17[15]) & (op.second_operand[15] ^ s17[15]));
				f[FLAG_N] = sub;
				f[FLAG_C] = s17[16];
				if (op.action == ACT_ADD16) begin
					// plain 16-bit add leaves s, z and pv alone
					f[FLAG_S] = op.flags_in[FLAG_S];
					f[FLAG_Z] = op.flags_in[FLAG_Z];
					f[FLAG_PV] = op.flags_in[FLAG_PV];
				end
				o.result_value = s17[15:0];
				o.memptr_out = op.first_operand + 16'd1;
				o.memptr_written = 1'b1;
			end
			ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SRL, ACT_SLL: begin
				case (op.action)
					ACT_RLC: begin v = {r[6:0], r[7]}; cout = r[7]; end
					ACT_RL: begin v = {r[6:0], cin}; cout = r[7]; end
					ACT_SLA: begin v = {r[6:0], 1'b0}; cout = r[7]; end
					ACT_SLL: begin v = {r[6:0], 1'b1}; cout = r[7]; end
					ACT_RRC: begin v = {r[0], r[7:1]}; cout = r[0]; end
					ACT_RR: begin v = {cin, r[7:1]}; cout = r[0]; end
					ACT_SRA: begin v = {r[7], r[7:1]}; cout = r[0]; end
					default: begin v = {1'b0, r[7:1]}; cout = r[0]; end
				endcase
				f = szxy_flags(v);
				f[FLAG_PV] = ~^v;
				f[FLAG_C] = cout;
				o.result_value = {8'h00, v};
			end
			ACT_BIT, ACT_BITMEMPTR: begin
				src = (op.action == ACT_BIT) ? r : op.memptr_in[15:8];
				f = 8'h00;
				f[FLAG_C] = cin;
				f[FLAG_H] = 1'b1;
				f[FLAG_5] = src[5];
				f[FLAG_3] = src[3];
				f[FLAG_Z] = ~r[op.bit_number];
				f[FLAG_PV] = ~r[op.bit_number];
				f[FLAG_S] = (op.bit_number == 3'd7) && r[7];
				o.result_value = {8'h00, a};
			end
			ACT_SET: begin
				o.result_value = {8'h00, r | mask};
			end
			ACT_RES: begin
				o.result_value = {8'h00, r & ~mask};
			end
			default: begin
			end
		endcase
		o.flags_out = f;
		return o;
	endfunction

	function automatic void queue_op(input action_t act, input word_t op1, input word_t op2,
		input byte_t fin, input bitnum_t bn, input word_t mp);
		alu_op_t op;
		op.action = act;
		op.first_operand = op1;
		op.second_operand = op2;
		op.flags_in = fin;
		op.bit_number = bn;
		op.memptr_in = mp;
		queued_ops.push_back(op);
	endfunction

	// random word with a bias toward carry and overflow boundaries
	function automatic word_t pick_word();
		word_t w;
		w = word_t'($urandom());
		case ($urandom_range(0, 11))
			0: w[7:0] = 8'h00;
			1: w[7:0] = 8'hFF;
			2: w[7:0] = 8'h7F;
			3: w[7:0] = 8'h80;
			4: w = 16'h0000;
			5: w = 16'hFFFF;
			6: w = 16'h7FFF;
			7: w = 16'h8000;
			default: begin
			end
		endcase
		return w;
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// request side: the expected outcome is queued as soon as the beat is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			src_gap <= 0;
			src_calm <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (queued_ops.size() != 0) begin
				next_op = queued_ops.pop_front();
				req_ch.action <= next_op.action;
				req_ch.first_operand <= next_op.first_operand;
				req_ch.second_operand <= next_op.second_operand;
				req_ch.flags_in <= next_op.flags_in;
				req_ch.bit_number <= next_op.bit_number;
				req_ch.memptr_in <= next_op.memptr_in;
				req_ch.valid <= 1'b1;
				pending_outcomes.push_back('{next_op.action, compute_alu_outcome(next_op)});
				if (src_calm != 0) begin
					src_calm <= src_calm - 1;
					src_gap <= 0;
				end else begin
					src_gap <= draw_gap();
					if ($urandom_range(0, 40) == 0)
						src_calm <= $urandom_range(30, 120);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result side: check each beat against the oldest outcome, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_gap <= 0;
			sink_calm <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected, result %h",
						rsp_ch.result_value));
				end else begin
					head_outcome = pending_outcomes.pop_front();
					if (rsp_ch.result_value !== head_outcome.want.result_value)
						report_mismatch($sformatf("action %0d result_value got %h want %h",
							head_outcome.action, rsp_ch.result_value,
							head_outcome.want.result_value));
					if (rsp_ch.flags_out !== head_outcome.want.flags_out)
						report_mismatch($sformatf("action %0d flags_out got %h want %h",
							head_outcome.action, rsp_ch.flags_out, head_outcome.want.flags_out));
					if (rsp_ch.memptr_out !== head_outcome.want.memptr_out)
						report_mismatch($sformatf("action %0d memptr_out got %h want %h",
							head_outcome.action, rsp_ch.memptr_out, head_outcome.want.memptr_out));
					if (rsp_ch.memptr_written !== head_outcome.want.memptr_written)
						report_mismatch($sformatf("action %0d memptr_written got %b want %b",
							head_outcome.action, rsp_ch.memptr_written,
							head_outcome.want.memptr_written));
				end
			end
			if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (sink_calm != 0) begin
					sink_calm <= sink_calm - 1;
				end else begin
					sink_gap <= draw_gap();
					if ($urandom_range(0, 40) == 0)
						sink_calm <= $urandom_range(30, 120);
				end
			end
		end
	end

	initial begin
		action_t act;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_INC;
		req_ch.first_operand = 16'h0000;
		req_ch.second_operand = 16'h0000;
		req_ch.flags_in = 8'h00;
		req_ch.bit_number = 3'd0;
		req_ch.memptr_in = 16'h0000;
		rsp_ch.ready = 1'b0;

		// directed corners; some upper operand bytes carry junk for the 8-bit ops
		queue_op(ACT_INC, 16'h1234, 16'hABFF, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_DEC, 16'h0000, 16'h5580, 8'hFF, 3'd0, 16'h0000);
		queue_op(ACT_ADD, 16'hFF7F, 16'h0001, 8'hFF, 3'd0, 16'h0000);
		queue_op(ACT_ADC, 16'hFFFF, 16'hFF00, 8'h01, 3'd0, 16'h0000);
		queue_op(ACT_SUB, 16'h0080, 16'h0001, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_SBC, 16'h0000, 16'h00FF, 8'h01, 3'd0, 16'h0000);
		queue_op(ACT_AND, 16'hFFFF, 16'h00FF, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_OR, 16'hFF00, 16'hFF00, 8'hFF, 3'd0, 16'h0000);
		queue_op(ACT_XOR, 16'h00AA, 16'hFF55, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_CP, 16'h0028, 16'h0028, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_ADD16, 16'hFFFF, 16'h0001, 8'hFF, 3'd0, 16'h1111);
		queue_op(ACT_ADC16, 16'h7FFF, 16'h0000, 8'h01, 3'd0, 16'h0000);
		queue_op(ACT_SBC16, 16'h0000, 16'hFFFF, 8'h01, 3'd0, 16'hFFFF);
		queue_op(ACT_RLC, 16'h0000, 16'h0080, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_RRC, 16'h0000, 16'h0001, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_RL, 16'h0000, 16'h0080, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_RR, 16'h0000, 16'h0001, 8'h01, 3'd0, 16'h0000);
		queue_op(ACT_SLA, 16'h0000, 16'h00FF, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_SRA, 16'h0000, 16'h0080, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_SRL, 16'h0000, 16'h0001, 8'hFF, 3'd0, 16'h0000);
		queue_op(ACT_SLL, 16'h0000, 16'h0000, 8'h00, 3'd0, 16'h0000);
		queue_op(ACT_BIT, 16'h00C3, 16'h0080, 8'h01, 3'd7, 16'h0000);
		queue_op(ACT_BITMEMPTR, 16'h0000, 16'h0000, 8'h00, 3'd3, 16'h28FF);
		queue_op(ACT_SET, 16'h0000, 16'hFF00, 8'h5A, 3'd7, 16'h0000);
		queue_op(ACT_RES, 16'h0000, 16'h00FF, 8'hA5, 3'd0, 16'h0000);
		queue_op(ACT_SPARE_LAST, 16'hBEEF, 16'h1234, 8'hC3, 3'd5, 16'h4321);

		repeat (1500) begin
			if ($urandom_range(0, 15) == 0)
				act = action_t'($urandom_range(ACT_RES + 1, ACT_SPARE_LAST));
			else
				act = action_t'($urandom_range(ACT_INC, ACT_RES));
			queue_op(act, pick_word(), pick_word(), byte_t'($urandom()),
				bitnum_t'($urandom_range(0, 7)), word_t'($urandom()));
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(negedge clk);
		while (queued_ops.size() != 0 || req_ch.valid || pending_outcomes.size() != 0);
		repeat (8) @(negedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_outcomes.size()));
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", pending_outcomes.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/z80alu_pkg.sv
rtl/core/z80alu_req_if.sv
rtl/core/z80alu_rsp_if.sv
rtl/core/z80_alu_with_flags.sv
sim/tb_top.sv
